// ===== rtl/icm_pkg.sv =====
// shared constants and types for the innovation consistency monitor
// no dependencies
`timescale 1ns / 1ps

package icm_pkg;

    // default datapath widths
    localparam int COUNT_WIDTH  = 16;
    localparam int SAMPLE_WIDTH = 16;

    // register widths
    localparam int THR_W    = 15;
    localparam int TOL_W    = 16;
    localparam int WARM_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // variance output format: q8.8, quotient carries 8 extra fraction bits
    localparam int VAR_W    = 16;
    localparam int VAR_FRAC = 8;
    localparam int VAR_QW   = VAR_W + VAR_FRAC;
    localparam logic [VAR_W-1:0] VAR_ONE = VAR_W'(256);
    localparam logic [VAR_W-1:0] VAR_MAX = '1;

    // register reset values
    localparam logic [THR_W-1:0]  OUTLIER_THR_RST = THR_W'(768);
    localparam logic [THR_W-1:0]  SIGMA_LIM_RST   = THR_W'(768);
    localparam logic [TOL_W-1:0]  VAR_TOL_RST     = TOL_W'(128);
    localparam logic [WARM_W-1:0] WARMUP_RST      = WARM_W'(20);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_LIM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_TOL     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP      = 2'd3;

    // reason codes
    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_BIAS    = 2'd1;
    localparam logic [1:0] REASON_DRIFT   = 2'd2;
    localparam logic [1:0] REASON_OUTLIER = 2'd3;

    // queue depths
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    // classification carried from front to back with each item
    typedef struct packed {
        logic clear;
        logic outlier;
    } item_flags_t;

endpackage

// ===== rtl/icm_fifo.sv =====
// small register queue with push/full and pop/empty sides
// no dependencies
`timescale 1ns / 1ps

module icm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/icm_front.sv =====
// front end: accepts commands, takes sample magnitude and outlier test
// depends on icm_pkg and icm_fifo
`timescale 1ns / 1ps

module icm_front #(
    parameter int SAMPLE_WIDTH = icm_pkg::SAMPLE_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            command,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample,
    input  logic [icm_pkg::THR_W-1:0]       outlier_threshold,
    input  logic                            q_pop,
    output logic                            q_empty,
    output icm_pkg::item_flags_t            q_flags,
    output logic signed [SAMPLE_WIDTH-1:0]  q_sample,
    output logic [SAMPLE_WIDTH-1:0]         q_mag
);

    localparam int CMPW = SAMPLE_WIDTH + icm_pkg::THR_W;
    localparam int QW   = $bits(icm_pkg::item_flags_t) + 2 * SAMPLE_WIDTH;

    logic [SAMPLE_WIDTH-1:0] mag;
    icm_pkg::item_flags_t    flags;
    logic [QW-1:0]           q_rdata;

    // magnitude of the most negative code still fits unsigned
    assign mag = sample[SAMPLE_WIDTH-1] ? $unsigned(-sample) : $unsigned(sample);

    always_comb
    begin
        flags.clear   = command;
        flags.outlier = !command && (CMPW'(mag) > CMPW'(outlier_threshold));
    end

    icm_fifo #(
        .WIDTH (QW),
        .DEPTH (icm_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({flags, sample, mag}),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {q_flags, q_sample, q_mag} = q_rdata;

endmodule

// ===== rtl/icm_back.sv =====
// back end: statistics update, serial multiply and divide, result build
// depends on icm_pkg
`timescale 1ns / 1ps

module icm_back #(
    parameter int COUNT_WIDTH  = icm_pkg::COUNT_WIDTH,
    parameter int SAMPLE_WIDTH = icm_pkg::SAMPLE_WIDTH,
    parameter int OUT_W = COUNT_WIDTH + 3 * SAMPLE_WIDTH + icm_pkg::VAR_W + 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  icm_pkg::item_flags_t            q_flags,
    input  logic signed [SAMPLE_WIDTH-1:0]  q_sample,
    input  logic [SAMPLE_WIDTH-1:0]         q_mag,
    output logic                            q_pop,
    input  logic [icm_pkg::THR_W-1:0]       mean_sigma_limit,
    input  logic [icm_pkg::TOL_W-1:0]       variance_tolerance,
    input  logic [icm_pkg::WARM_W-1:0]      warmup_count,
    input  logic                            out_full,
    output logic                            out_push,
    output logic [OUT_W-1:0]                out_data
);

    localparam int CW    = COUNT_WIDTH;
    localparam int SW    = SAMPLE_WIDTH;
    localparam int SMW   = CW + SW;
    localparam int SSW   = CW + 2 * SW;
    localparam int NW    = 2 * CW + 2 * SW;
    localparam int DW    = 2 * CW;
    localparam int QV    = icm_pkg::VAR_QW;
    localparam int VW    = icm_pkg::VAR_W;
    localparam int NSTEP = (SMW > QV) ? SMW : QV;
    localparam int STW   = $clog2(NSTEP);
    localparam int CMPW  = NW + DW + QV;
    localparam int BW    = 2 * SW + CW + 2 * icm_pkg::THR_W;
    localparam int WW    = CW + icm_pkg::WARM_W;
    localparam int TW    = VW + icm_pkg::TOL_W;
    localparam logic [CW-1:0] CMAX = '1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SQ    = 11'b000_0000_0010,
        S_ACC   = 11'b000_0000_0100,
        S_INIT  = 11'b000_0000_1000,
        S_ITER  = 11'b000_0001_0000,
        S_VPREP = 11'b000_0010_0000,
        S_VCHK  = 11'b000_0100_0000,
        S_VDIV  = 11'b000_1000_0000,
        S_MB    = 11'b001_0000_0000,
        S_BIAS  = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // statistics
    logic [CW-1:0]         count_reg;
    logic signed [SMW-1:0] sum_reg;
    logic [SSW-1:0]        sumsq_reg;
    logic [SW-1:0]         peak_reg;

    // current item
    logic                  clear_reg;
    logic                  outl_reg;
    logic signed [SW-1:0]  s_reg;
    logic [SW-1:0]         smag_reg;
    logic [2*SW-1:0]       sq_reg;

    // shift-add multipliers and mean divider
    logic [STW-1:0]        step_reg;
    logic                  sneg_reg;
    logic [NW-1:0]         a_acc_reg, a_mc_reg;
    logic [CW-1:0]         a_mp_reg;
    logic [NW-1:0]         b_acc_reg, b_mc_reg;
    logic [SMW-1:0]        b_mp_reg;
    logic [DW-1:0]         d_acc_reg, d_mc_reg;
    logic [CW-1:0]         d_mp_reg;
    logic [CW-1:0]         mrem_reg;
    logic [SW-1:0]         mlow_reg, mq_reg;

    // variance divider
    logic [NW-1:0]         num_reg;
    logic [DW-1:0]         vrem_reg;
    logic [QV-1:0]         vlow_reg, vq_reg;
    logic                  vsat_reg;

    // bias test
    logic [2*SW-1:0]       mm2_reg;
    logic [2*icm_pkg::THR_W-1:0] k2_reg;
    logic signed [SW-1:0]  mean_reg;
    logic                  bias_reg;

    logic [SMW-1:0]        sum_mag;
    logic [CW:0]           m_r2;
    logic                  m_ge;
    logic [DW:0]           v_r2;
    logic                  v_ge;
    logic [NW+DW-1:0]      num_wide;
    logic                  last_iter;
    logic                  last_vdiv;
    logic                  few_samples;
    logic [VW-1:0]         var_val;
    logic [VW-1:0]         var_dist;
    logic                  warm;
    logic                  drift;
    logic [1:0]            reason;
    logic                  bias_flag;

    assign sum_mag     = sum_reg[SMW-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
    assign last_iter   = (step_reg == STW'(SMW - 1));
    assign last_vdiv   = (step_reg == STW'(QV - 1));
    assign few_samples = (count_reg < CW'(2));
    assign num_wide    = (NW + DW)'(num_reg);

    // restoring divide steps
    assign m_r2 = {mrem_reg, mlow_reg[SW-1]};
    assign m_ge = (m_r2 >= {1'b0, count_reg});
    assign v_r2 = {vrem_reg, vlow_reg[QV-1]};
    assign v_ge = (v_r2 >= {1'b0, d_acc_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_flags.clear ? S_EMIT : S_SQ;
                end
            end
            S_SQ:    state_next = S_ACC;
            S_ACC:   state_next = S_INIT;
            S_INIT:  state_next = S_ITER;
            S_ITER:  state_next = last_iter ? S_VPREP : S_ITER;
            S_VPREP: state_next = S_VCHK;
            S_VCHK:
            begin
                state_next = (few_samples || (CMPW'(d_acc_reg) << QV) <= CMPW'(num_reg))
                           ? S_MB : S_VDIV;
            end
            S_VDIV:  state_next = last_vdiv ? S_MB : S_VDIV;
            S_MB:    state_next = S_BIAS;
            S_BIAS:  state_next = S_EMIT;
            S_EMIT:  state_next = out_full ? S_EMIT : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_push = (state_reg == S_EMIT) && !out_full;

    // control state and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && q_flags.clear)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sumsq_reg <= '0;
                peak_reg  <= '0;
            end
            else if (state_reg == S_ACC)
            begin
                if (count_reg != CMAX)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SMW'(s_reg);
                    sumsq_reg <= sumsq_reg + SSW'(sq_reg);
                end
                if (smag_reg > peak_reg)
                begin
                    peak_reg <= smag_reg;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                clear_reg <= q_flags.clear;
                outl_reg  <= q_flags.outlier;
                s_reg     <= q_sample;
                smag_reg  <= q_mag;
            end
            S_SQ:
            begin
                sq_reg <= (2 * SW)'(smag_reg) * (2 * SW)'(smag_reg);
            end
            S_INIT:
            begin
                step_reg  <= '0;
                sneg_reg  <= sum_reg[SMW-1];
                a_acc_reg <= '0;
                a_mc_reg  <= NW'(sumsq_reg);
                a_mp_reg  <= count_reg;
                b_acc_reg <= '0;
                b_mc_reg  <= NW'(sum_mag);
                b_mp_reg  <= sum_mag;
                d_acc_reg <= '0;
                d_mc_reg  <= DW'(count_reg);
                d_mp_reg  <= count_reg - 1'b1;
                mrem_reg  <= CW'(sum_mag >> SW);
                mlow_reg  <= SW'(sum_mag);
                mq_reg    <= '0;
            end
            S_ITER:
            begin
                step_reg  <= step_reg + 1'b1;
                if (a_mp_reg[0])
                begin
                    a_acc_reg <= a_acc_reg + a_mc_reg;
                end
                a_mc_reg <= a_mc_reg << 1;
                a_mp_reg <= a_mp_reg >> 1;
                if (b_mp_reg[0])
                begin
                    b_acc_reg <= b_acc_reg + b_mc_reg;
                end
                b_mc_reg <= b_mc_reg << 1;
                b_mp_reg <= b_mp_reg >> 1;
                if (d_mp_reg[0])
                begin
                    d_acc_reg <= d_acc_reg + d_mc_reg;
                end
                d_mc_reg <= d_mc_reg << 1;
                d_mp_reg <= d_mp_reg >> 1;
                if (step_reg < STW'(SW))
                begin
                    mrem_reg <= m_ge ? CW'(m_r2 - {1'b0, count_reg}) : CW'(m_r2);
                    mlow_reg <= mlow_reg << 1;
                    mq_reg   <= {mq_reg[SW-2:0], m_ge};
                end
            end
            S_VPREP:
            begin
                num_reg <= (a_acc_reg > b_acc_reg) ? a_acc_reg - b_acc_reg : '0;
            end
            S_VCHK:
            begin
                step_reg <= '0;
                vsat_reg <= (CMPW'(d_acc_reg) << QV) <= CMPW'(num_reg);
                vrem_reg <= DW'(num_wide >> QV);
                vlow_reg <= QV'(num_wide);
                vq_reg   <= '0;
            end
            S_VDIV:
            begin
                step_reg <= step_reg + 1'b1;
                vrem_reg <= v_ge ? DW'(v_r2 - {1'b0, d_acc_reg}) : DW'(v_r2);
                vlow_reg <= vlow_reg << 1;
                vq_reg   <= {vq_reg[QV-2:0], v_ge};
            end
            S_MB:
            begin
                mm2_reg  <= (2 * SW)'(mq_reg) * (2 * SW)'(mq_reg);
                k2_reg   <= (2 * icm_pkg::THR_W)'(mean_sigma_limit)
                          * (2 * icm_pkg::THR_W)'(mean_sigma_limit);
                mean_reg <= (count_reg == '0) ? '0
                          : (sneg_reg ? $signed(-mq_reg) : $signed(mq_reg));
            end
            S_BIAS:
            begin
                bias_reg <= (BW'(mm2_reg) * BW'(count_reg)) > BW'(k2_reg);
            end
            default:
            begin
            end
        endcase
    end

    // result fields
    always_comb
    begin
        if (few_samples)
        begin
            var_val = '0;
        end
        else if (vsat_reg)
        begin
            var_val = icm_pkg::VAR_MAX;
        end
        else
        begin
            var_val = vq_reg[QV-1 -: VW];
        end
        var_dist  = (var_val > icm_pkg::VAR_ONE) ? var_val - icm_pkg::VAR_ONE
                                                 : icm_pkg::VAR_ONE - var_val;
        warm      = WW'(count_reg) >= WW'(warmup_count);
        bias_flag = warm && bias_reg;
        drift     = warm && (TW'(var_dist) > TW'(variance_tolerance));
        if (!warm)
        begin
            reason = icm_pkg::REASON_NONE;
        end
        else if (bias_flag)
        begin
            reason = icm_pkg::REASON_BIAS;
        end
        else if (drift)
        begin
            reason = icm_pkg::REASON_DRIFT;
        end
        else if (outl_reg)
        begin
            reason = icm_pkg::REASON_OUTLIER;
        end
        else
        begin
            reason = icm_pkg::REASON_NONE;
        end

        if (clear_reg)
        begin
            out_data = '0;
        end
        else
        begin
            out_data = {count_reg, s_reg, peak_reg, mean_reg, var_val,
                        outl_reg, bias_flag, drift, reason, count_reg == CMAX};
        end
    end

endmodule

// ===== rtl/innovation_consistency_monitor.sv =====
// top level of the innovation consistency monitor: registers, front, back, result queue
// depends on icm_pkg, icm_fifo, icm_front, icm_back
// a sample goes through square, accumulate, init, the 32-step serial multiply and mean
// divide, the 24-step variance divide (skipped with fewer than two samples or a
// saturating quotient), the mean and bias steps and emit; a clear goes straight to emit
// the back end starts the next queued command only once the previous result is pushed
// reset: rst_n clears statistics, queues and sequencer at once; registers take defaults
`timescale 1ns / 1ps

module innovation_consistency_monitor #(
    parameter int COUNT_WIDTH  = icm_pkg::COUNT_WIDTH,
    parameter int SAMPLE_WIDTH = icm_pkg::SAMPLE_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command side
    input  logic                                push,
    output logic                                full,
    input  logic                                command,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    // result side
    output logic                                empty,
    input  logic                                pop,
    output logic [COUNT_WIDTH-1:0]              sample_count,
    output logic signed [SAMPLE_WIDTH-1:0]      newest_sample,
    output logic [SAMPLE_WIDTH-1:0]             max_magnitude,
    output logic signed [SAMPLE_WIDTH-1:0]      mean_estimate,
    output logic [icm_pkg::VAR_W-1:0]           running_variance,
    output logic                                outlier,
    output logic                                bias_alarm,
    output logic                                variance_drift,
    output logic [1:0]                          reason,
    output logic                                count_saturated,
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [icm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [icm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int OUT_W = COUNT_WIDTH + 3 * SAMPLE_WIDTH + icm_pkg::VAR_W + 6;

    // configuration registers
    logic [icm_pkg::THR_W-1:0]  outlier_threshold_reg;
    logic [icm_pkg::THR_W-1:0]  mean_sigma_limit_reg;
    logic [icm_pkg::TOL_W-1:0]  variance_tolerance_reg;
    logic [icm_pkg::WARM_W-1:0] warmup_count_reg;

    // front to back queue
    logic                          q_pop;
    logic                          q_empty;
    icm_pkg::item_flags_t          q_flags;
    logic signed [SAMPLE_WIDTH-1:0] q_sample;
    logic [SAMPLE_WIDTH-1:0]       q_mag;

    // back to result queue
    logic                          res_push;
    logic                          res_full;
    logic [OUT_W-1:0]              res_wdata;
    logic [OUT_W-1:0]              res_rdata;

    // writes are always taken; cfg_ready is tied high
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outlier_threshold_reg  <= icm_pkg::OUTLIER_THR_RST;
            mean_sigma_limit_reg   <= icm_pkg::SIGMA_LIM_RST;
            variance_tolerance_reg <= icm_pkg::VAR_TOL_RST;
            warmup_count_reg       <= icm_pkg::WARMUP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                icm_pkg::CFG_OUTLIER_THR:
                    outlier_threshold_reg <= cfg_data[icm_pkg::THR_W-1:0];
                icm_pkg::CFG_SIGMA_LIM:
                    mean_sigma_limit_reg <= cfg_data[icm_pkg::THR_W-1:0];
                icm_pkg::CFG_VAR_TOL:
                    variance_tolerance_reg <= cfg_data[icm_pkg::TOL_W-1:0];
                icm_pkg::CFG_WARMUP:
                    warmup_count_reg <= cfg_data[icm_pkg::WARM_W-1:0];
            endcase
        end
    end

    // front: accepts transfers, classifies clear vs sample, outlier test
    icm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .command           (command),
        .sample            (sample),
        .outlier_threshold (outlier_threshold_reg),
        .q_pop             (q_pop),
        .q_empty           (q_empty),
        .q_flags           (q_flags),
        .q_sample          (q_sample),
        .q_mag             (q_mag)
    );

    // back: accumulates and runs the serial mean and variance arithmetic
    icm_back #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .OUT_W        (OUT_W)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_empty            (q_empty),
        .q_flags            (q_flags),
        .q_sample           (q_sample),
        .q_mag              (q_mag),
        .q_pop              (q_pop),
        .mean_sigma_limit   (mean_sigma_limit_reg),
        .variance_tolerance (variance_tolerance_reg),
        .warmup_count       (warmup_count_reg),
        .out_full           (res_full),
        .out_push           (res_push),
        .out_data           (res_wdata)
    );

    // result queue keeps the back end running while results wait
    icm_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (icm_pkg::RES_QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign {sample_count, newest_sample, max_magnitude, mean_estimate, running_variance,
            outlier, bias_alarm, variance_drift, reason, count_saturated} = res_rdata;

`ifndef SYNTHESIS
    // a reason other than none only after warmup
    a_reason_warm: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reason != icm_pkg::REASON_NONE) |->
            ({{icm_pkg::WARM_W{1'b0}}, sample_count} >=
             {{COUNT_WIDTH{1'b0}}, warmup_count_reg}))
        else $error("reason reported during warmup");

    // a reason code of bias or none agrees with the bias flag
    a_reason_prio: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (reason == icm_pkg::REASON_BIAS || reason == icm_pkg::REASON_NONE)) |->
            (bias_alarm == (reason == icm_pkg::REASON_BIAS)))
        else $error("reason code does not match bias flag");

    // saturation flag only with an all-ones count
    a_sat_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && count_saturated) |-> (&sample_count))
        else $error("saturation flag with count below maximum");
`endif

endmodule

// ===== tb/sv/innovation_consistency_monitor_tb.sv =====
// testbench for innovation_consistency_monitor: a scoreboard class predicts every result
// from its own copy of the statistics, plain tasks push samples and a process pops results
// depends on icm_pkg and the innovation_consistency_monitor rtl
`timescale 1ns / 1ps

module innovation_consistency_monitor_tb;
    import icm_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam longint unsigned COUNT_MAX = 65535;

    // one result item as seen on the result ports
    typedef struct {
        logic [15:0] cnt;
        logic [15:0] last;
        logic [15:0] peak;
        logic [15:0] mean;
        logic [15:0] var_q;
        logic        outl;
        logic        bias;
        logic        drift;
        logic [1:0]  why;
        logic        sat;
    } stats_t;

    // statistics predictor and queue of expected result items
    class stats_scoreboard;
        stats_t expected_stats[$];
        int     mismatches;
        // register copy
        logic [THR_W-1:0]  outlier_thr;
        logic [THR_W-1:0]  sigma_lim;
        logic [TOL_W-1:0]  var_tol;
        logic [WARM_W-1:0] warmup;
        // statistics copy
        longint unsigned n;
        longint          sum;
        longint unsigned sumsq;
        longint unsigned peak_mag;

        function new();
            outlier_thr = OUTLIER_THR_RST;
            sigma_lim   = SIGMA_LIM_RST;
            var_tol     = VAR_TOL_RST;
            warmup      = WARMUP_RST;
            n = 0; sum = 0; sumsq = 0; peak_mag = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_OUTLIER_THR: outlier_thr = val[THR_W-1:0];
                CFG_SIGMA_LIM:   sigma_lim   = val[THR_W-1:0];
                CFG_VAR_TOL:     var_tol     = val;
                default:         warmup      = val;
            endcase
        endfunction

        // note an accepted command and predict its result
        function void note_input(logic cmd, logic signed [15:0] s);
            stats_t r;
            longint          sv;
            longint unsigned smag, smean_mag, q, a, b, num, v, d;
            r = '{default: '0};
            if (cmd)
            begin
                n = 0; sum = 0; sumsq = 0; peak_mag = 0;
                expected_stats.push_back(r);
                return;
            end
            sv   = s;
            smag = (sv < 0) ? -sv : sv;
            if (n < COUNT_MAX)
            begin
                n++;
                sum   += sv;
                sumsq += smag * smag;
            end
            if (smag > peak_mag)
                peak_mag = smag;
            smean_mag = 0;
            v = 0;
            if (n != 0)
            begin
                q = ((sum < 0) ? -sum : sum) / n;
                smean_mag = q;
                r.mean = (sum < 0) ? 16'(-q) : 16'(q);
            end
            if (n >= 2)
            begin
                a   = n * sumsq;
                b   = ((sum < 0) ? -sum : sum) * ((sum < 0) ? -sum : sum);
                num = (a > b) ? a - b : 0;
                v   = (num / (n * (n - 1))) >> 8;
                if (v > 64'hFFFF)
                    v = 64'hFFFF;
            end
            r.outl = smag > outlier_thr;
            r.why  = REASON_NONE;
            if (n >= warmup)
            begin
                d = (v > 256) ? v - 256 : 256 - v;
                r.bias  = smean_mag * smean_mag * n > longint'(sigma_lim) * sigma_lim;
                r.drift = d > var_tol;
                if (r.bias)
                    r.why = REASON_BIAS;
                else if (r.drift)
                    r.why = REASON_DRIFT;
                else if (r.outl)
                    r.why = REASON_OUTLIER;
            end
            r.cnt   = 16'(n);
            r.last  = s;
            r.peak  = 16'(peak_mag);
            r.var_q = 16'(v);
            r.sat   = (n == COUNT_MAX);
            expected_stats.push_back(r);
        endfunction

        function void cmp(string name, logic [15:0] e, logic [15:0] a);
            if (e !== a)
            begin
                $error("%s: expected %0h, got %0h", name, e, a);
                mismatches++;
            end
        endfunction

        function void check_result(stats_t got);
            stats_t e;
            if (expected_stats.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                mismatches++;
                return;
            end
            e = expected_stats.pop_front();
            cmp("sample_count", e.cnt, got.cnt);
            cmp("newest_sample", e.last, got.last);
            cmp("max_magnitude", e.peak, got.peak);
            cmp("mean_estimate", e.mean, got.mean);
            cmp("running_variance", e.var_q, got.var_q);
            cmp("outlier", 16'(e.outl), 16'(got.outl));
            cmp("bias_alarm", 16'(e.bias), 16'(got.bias));
            cmp("variance_drift", 16'(e.drift), 16'(got.drift));
            cmp("reason", 16'(e.why), 16'(got.why));
            cmp("count_saturated", 16'(e.sat), 16'(got.sat));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push, full, command;
    logic signed [15:0] sample;
    logic empty, pop;
    logic [15:0] sample_count, max_magnitude, running_variance;
    logic signed [15:0] newest_sample, mean_estimate;
    logic outlier, bias_alarm, variance_drift, count_saturated;
    logic [1:0] reason;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stats_scoreboard sb;

    // idle rates in percent, changed per phase
    int send_idle_pct;
    int pop_stall_pct;
    // long receiver hold-off, counted down in the pop process
    int pop_hold_cycles;

    innovation_consistency_monitor u_top (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .command(command), .sample(sample),
        .empty(empty), .pop(pop),
        .sample_count(sample_count), .newest_sample(newest_sample),
        .max_magnitude(max_magnitude), .mean_estimate(mean_estimate),
        .running_variance(running_variance), .outlier(outlier),
        .bias_alarm(bias_alarm), .variance_drift(variance_drift),
        .reason(reason), .count_saturated(count_saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // safety net against a hung handshake
    initial
    begin
        #(CLK_PERIOD * 2_000_000);
        $display("FAILURE");
        $finish;
    end

    // result side: check on each transfer, then choose pop for the next edge
    initial
    begin
        stats_t got;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got.cnt   = sample_count;
                got.last  = newest_sample;
                got.peak  = max_magnitude;
                got.mean  = mean_estimate;
                got.var_q = running_variance;
                got.outl  = outlier;
                got.bias  = bias_alarm;
                got.drift = variance_drift;
                got.why   = reason;
                got.sat   = count_saturated;
                sb.check_result(got);
            end
            if (pop_hold_cycles > 0)
            begin
                pop_hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // one command transfer; push stays high into the next call unless a gap is drawn
    task automatic send_cmd(logic cmd, logic signed [15:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        command <= cmd;
        sample  <= s;
        do
            @(posedge clk);
        while (full);
        sb.note_input(cmd, s);
    endtask

    // register write; caller lowers cfg_valid after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic set_regs(logic [15:0] thr, logic [15:0] lim, logic [15:0] tol,
                            logic [15:0] warm);
        write_reg(CFG_OUTLIER_THR, thr);
        write_reg(CFG_SIGMA_LIM, lim);
        write_reg(CFG_VAR_TOL, tol);
        write_reg(CFG_WARMUP, warm);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every outstanding result, then a little slack
    task automatic drain();
        push <= 1'b0;
        while (sb.expected_stats.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // noise-like sample: sum of uniforms gives roughly unit variance around a bias
    function automatic logic signed [15:0] draw_sample(int bias, int spread);
        int acc;
        acc = bias;
        repeat (4) acc += $signed($urandom_range(2 * spread)) - spread;
        return 16'(acc);
    endfunction

    initial
    begin
        logic signed [15:0] s;
        int bias, spread, n_items, mode;
        sb = new();
        rst_n = 1'b0;
        push = 1'b0; command = 1'b0; sample = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        send_idle_pct = 0; pop_stall_pct = 0; pop_hold_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, threshold edges, clear, then past the default warmup
        send_cmd(1'b1, 16'sh7FFF);
        send_cmd(1'b0, 16'sh7FFF);
        send_cmd(1'b0, -16'sh8000);
        send_cmd(1'b0, 16'sh0000);
        send_cmd(1'b0, -16'sh0001);
        send_cmd(1'b0, 16'sd768);
        send_cmd(1'b0, 16'sd769);
        send_cmd(1'b0, -16'sd769);
        send_cmd(1'b1, 16'sh0000);
        repeat (22) send_cmd(1'b0, draw_sample(0, 220));
        drain();
        // warmup of zero applies bias and drift from the first sample; large limits
        set_regs(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000);
        send_cmd(1'b1, 16'sh0000);
        send_cmd(1'b0, 16'sd300);
        send_cmd(1'b0, -16'sd300);
        drain();

        // random phases over register settings and idle modes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                1: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: set_regs(16'd768, 16'd768, 16'd128, 16'd20);
                3: set_regs(16'd256, 16'd512, 16'd64, 16'd5);
                default: set_regs(16'($urandom), 16'($urandom_range(2000)),
                                  16'($urandom_range(400)), 16'($urandom_range(40)));
            endcase
            mode = ph % 4;
            send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 19 : 63) : 0;
            pop_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 19 : 63) : 0;
            // fill the block and hold off popping its results once
            if (ph == 2)
                pop_hold_cycles = 600;
            bias   = (ph % 3 == 0) ? 0 : $signed($urandom_range(200)) - 100;
            spread = 60 + $urandom_range(300);
            n_items = (ph == 1) ? 100 : 140;
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(99) < 2)
                    send_cmd(1'b1, 16'($urandom));
                else if ($urandom_range(99) < 10)
                    send_cmd(1'b0, 16'($urandom));
                else
                begin
                    s = draw_sample(bias, spread);
                    send_cmd(1'b0, s);
                end
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_stats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
